[rtl/btc_pkg.sv]
package btc_pkg;

  // Permutation table geometry: sixteen 4-bit entries.
  localparam int unsigned TABLE_SLOTS = 16;
  localparam int unsigned ENTRY_W     = 4;
  localparam int unsigned LEN_W       = 5;
  localparam int unsigned CFG_DATA_W  = 64;
  localparam int unsigned CFG_IDX_W   = 2;

  localparam logic [7:0] PAD_BYTE = 8'h20;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_LEN    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PERM_TABLE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DECRYPT_MODE = 2'd2;

  localparam logic [LEN_W-1:0]      RESET_BLOCK_LEN  = 5'd1;
  localparam logic [CFG_DATA_W-1:0] RESET_PERM_TABLE = 64'hFEDC_BA98_7654_3210;

  typedef struct packed {
    logic [7:0] data;
    logic       block_last;
    logic       stream_last;
  } out_item_t;

endpackage

[rtl/block_transposition_cipher_top.sv]
// Block transposition cipher over a byte stream. Bytes are written into a
// block store memory until block_len bytes are held or end_of_stream is seen;
// the block is then read back in permuted order (encrypt: out[j] = in[perm[j]],
// decrypt: the inverse), one byte per cycle through the store's single read
// port while the output buffering has room. A filling byte is accepted every
// cycle that in_stall is low; in_stall is high while a block is read out
// (only its kept bytes after stripping, and longer while out_stall holds the
// output, as reads wait for room in it). Encrypt pads a partial
// final block with spaces; decrypt drops a partial final block and strips
// trailing spaces from the final block. With an invalid permutation table no
// output is produced. Output bytes pass through an output register with a
// skid entry, so reads continue at full rate while the consumer is ready.
module block_transposition_cipher_top #(
  parameter int unsigned MAX_BLOCK = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [btc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [btc_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [7:0]                        data_byte,
  input  logic                              end_of_stream,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [7:0]                        out_byte,
  output logic                              block_last,
  output logic                              stream_last
);

  localparam int unsigned AW = $clog2(MAX_BLOCK);
  localparam int unsigned LW = btc_pkg::LEN_W;
  localparam int unsigned EW = btc_pkg::ENTRY_W;
  localparam int unsigned NS = btc_pkg::TABLE_SLOTS;

  // Configuration registers.
  logic [LW-1:0]                     block_len;
  logic [btc_pkg::CFG_DATA_W-1:0]    perm_table;
  logic                              decrypt_mode;
  logic                              table_valid;

  // Fill side.
  logic [LW-1:0]                     fill_count;
  logic [NS-1:0]                     space_mask;

  // Block store memory.
  logic [7:0]                        store [MAX_BLOCK];
  logic [7:0]                        mem_q;

  // Read-out sequencer.
  logic                              em_active;
  logic [LW-1:0]                     em_idx;
  logic [LW-1:0]                     em_n;
  logic [LW-1:0]                     em_fill;
  logic                              em_eos;

  // Read pipeline and output buffering.
  logic                              rd_pend;
  logic                              rd_pad;
  logic                              rd_blast;
  logic                              rd_slast;
  btc_pkg::out_item_t                rd_item;
  btc_pkg::out_item_t                out_q;
  btc_pkg::out_item_t                skid_q;
  logic                              skid_valid;

  logic [EW-1:0]                     ent [NS];
  logic [EW-1:0]                     chk_ent [NS];
  logic [LW-1:0]                     chk_len;
  logic                              chk_ok;
  logic [NS-1:0]                     hit;
  logic                              cfg_table_wr;

  logic                              in_take;
  logic [LW-1:0]                     fill_next;
  logic                              blk_done;
  logic [NS-1:0]                     mask_now;
  logic [LW-1:0]                     strip_n;
  logic [LW-1:0]                     start_n;

  logic [EW-1:0]                     src;
  logic                              issue;
  logic                              out_take;
  logic                              out_free;
  logic [1:0]                        occ;
  logic                              issue_last;

  // Table entries, current and as they will be after a table write.
  always_comb begin
    cfg_table_wr = cfg_we && (cfg_index == btc_pkg::REG_BLOCK_LEN ||
                              cfg_index == btc_pkg::REG_PERM_TABLE);
    chk_len = block_len;
    for (int j = 0; j < NS; j++) begin
      ent[j]     = perm_table[j*EW +: EW];
      chk_ent[j] = perm_table[j*EW +: EW];
    end
    if (cfg_we && cfg_index == btc_pkg::REG_BLOCK_LEN) begin
      chk_len = cfg_data[LW-1:0];
    end
    if (cfg_we && cfg_index == btc_pkg::REG_PERM_TABLE) begin
      for (int j = 0; j < NS; j++) begin
        chk_ent[j] = cfg_data[j*EW +: EW];
      end
    end
  end

  // The first chk_len entries form a permutation exactly when every value
  // below chk_len is hit by one of them.
  always_comb begin
    hit = '0;
    for (int v = 0; v < NS; v++) begin
      for (int j = 0; j < NS; j++) begin
        if (LW'(j) < chk_len && chk_ent[j] == EW'(v)) begin
          hit[v] = 1'b1;
        end
      end
    end
    chk_ok = (chk_len != '0) && (chk_len <= LW'(NS)) &&
             ({27'd0, chk_len} <= 32'(MAX_BLOCK));
    for (int v = 0; v < NS; v++) begin
      if (LW'(v) < chk_len && !hit[v]) begin
        chk_ok = 1'b0;
      end
    end
  end

  // Fill side: the closing byte also decides the length of the read-out.
  always_comb begin
    in_take   = in_valid && !in_stall;
    fill_next = fill_count + LW'(1);
    blk_done  = (fill_next == block_len) || end_of_stream;
    mask_now  = space_mask;
    mask_now[ent[fill_count[EW-1:0]]] = (data_byte == btc_pkg::PAD_BYTE);
    strip_n = '0;
    for (int j = 0; j < NS; j++) begin
      if (LW'(j) < block_len && !mask_now[j]) begin
        strip_n = LW'(j + 1);
      end
    end
    start_n = (decrypt_mode && end_of_stream) ? strip_n : block_len;
  end

  assign in_stall = em_active;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_len    <= btc_pkg::RESET_BLOCK_LEN;
      perm_table   <= btc_pkg::RESET_PERM_TABLE;
      decrypt_mode <= 1'b0;
      table_valid  <= 1'b1;
      fill_count   <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          btc_pkg::REG_BLOCK_LEN:    block_len    <= cfg_data[LW-1:0];
          btc_pkg::REG_PERM_TABLE:   perm_table   <= cfg_data;
          btc_pkg::REG_DECRYPT_MODE: decrypt_mode <= cfg_data[0];
          default: ;
        endcase
      end
      if (cfg_table_wr) begin
        table_valid <= chk_ok;
        fill_count  <= '0;
      end else if (in_take) begin
        if (!table_valid) begin
          if (end_of_stream) begin
            fill_count <= '0;
          end
        end else if (blk_done) begin
          fill_count <= '0;
        end else begin
          fill_count <= fill_next;
        end
      end
    end
  end

  // Space flags are kept per output position so stripping is known when the
  // block closes.
  always_ff @(posedge clk) begin
    if (in_take && table_valid) begin
      space_mask <= mask_now;
    end
  end

  // Source of output position em_idx: the table entry when encrypting, the
  // position whose entry equals em_idx when decrypting.
  always_comb begin
    src = ent[em_idx[EW-1:0]];
    if (decrypt_mode) begin
      src = '0;
      for (int i = 0; i < NS; i++) begin
        if (LW'(i) < block_len && ent[i] == em_idx[EW-1:0]) begin
          src = EW'(i);
        end
      end
    end
  end

  always_comb begin
    out_take   = out_valid && !out_stall;
    out_free   = !out_valid || !out_stall;
    occ        = {1'b0, rd_pend} + {1'b0, out_valid} + {1'b0, skid_valid} -
                 {1'b0, out_take};
    issue      = em_active && (occ <= 2'd1);
    issue_last = (em_idx == em_n - LW'(1));
  end

  // Block store: one write port for filling, one registered read port.
  always_ff @(posedge clk) begin
    if (in_take && table_valid) begin
      store[AW'(fill_count)] <= data_byte;
    end
    if (issue) begin
      mem_q <= store[AW'(src)];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      em_active <= 1'b0;
    end else if (in_take && table_valid && blk_done) begin
      // A partial block in decrypt mode is dropped; stripping may leave none.
      em_active <= !(decrypt_mode && fill_next != block_len) && (start_n != '0);
    end else if (issue && issue_last) begin
      em_active <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take && table_valid && blk_done) begin
      em_idx  <= '0;
      em_n    <= start_n;
      em_fill <= fill_next;
      em_eos  <= end_of_stream;
    end else if (issue) begin
      em_idx <= em_idx + LW'(1);
    end
    if (issue) begin
      rd_pad   <= !decrypt_mode && ({1'b0, src} >= em_fill);
      rd_blast <= issue_last;
      rd_slast <= issue_last && em_eos;
    end
  end

  always_comb begin
    rd_item.data        = rd_pad ? btc_pkg::PAD_BYTE : mem_q;
    rd_item.block_last  = rd_blast;
    rd_item.stream_last = rd_slast;
  end

  // Read data lands in the output register, or in the skid entry when the
  // output register is held by a stalled transfer or an older byte waits in skid.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend    <= 1'b0;
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      rd_pend <= issue;
      if (out_free) begin
        if (skid_valid) begin
          out_valid  <= 1'b1;
          skid_valid <= rd_pend;
        end else begin
          out_valid <= rd_pend;
        end
      end else if (rd_pend) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        out_q  <= skid_q;
        skid_q <= rd_item;
      end else begin
        out_q <= rd_item;
      end
    end else if (rd_pend) begin
      skid_q <= rd_item;
    end
  end

  assign out_byte    = out_q.data;
  assign block_last  = out_q.block_last;
  assign stream_last = out_q.stream_last;

endmodule

[rtl/btc_checker.sv]
module btc_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic       block_last,
  input logic       stream_last
);

  // A held output transfer keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_byte) &&
                              $stable(block_last) && $stable(stream_last))
    else $error("output changed while stalled");

  // The end of the stream always closes a block.
  a_stream_closes_block: assert property (@(posedge clk) disable iff (rst)
    out_valid && stream_last |-> block_last)
    else $error("stream_last without block_last");

  // Input only stalls once a transfer has closed a block.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(in_stall) |-> $past(in_valid && !in_stall))
    else $error("input stalled without a closing transfer");

  // Reset leaves both channels quiet.
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("channels active after reset");

endmodule

bind block_transposition_cipher_top btc_checker u_btc_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_byte    (out_byte),
  .block_last  (block_last),
  .stream_last (stream_last)
);

[dv/btc_stream_checker.sv]
// Watches both byte channels and the register port, keeps its own copy of the
// cipher state, and compares every output transfer against the oldest
// predicted byte.
module btc_stream_checker #(
  parameter int unsigned MAX_BLOCK = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [btc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [btc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic [7:0]                     data_byte,
  input  logic                           end_of_stream,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic [7:0]                     out_byte,
  input  logic                           block_last,
  input  logic                           stream_last,
  output int                             fail_count,
  output int                             pending_results
);

  logic [btc_pkg::LEN_W-1:0]      blk_len;
  logic [btc_pkg::CFG_DATA_W-1:0] perm_word;
  logic                           decrypting;
  logic [7:0]                     held [btc_pkg::TABLE_SLOTS];
  int                             fill;
  bit                             perm_ok;
  btc_pkg::out_item_t             cipher_bytes [$];
  btc_pkg::out_item_t             want;

  function automatic bit is_permutation(logic [btc_pkg::LEN_W-1:0] len,
                                        logic [btc_pkg::CFG_DATA_W-1:0] tbl);
    bit [btc_pkg::TABLE_SLOTS-1:0] seen;
    logic [btc_pkg::ENTRY_W-1:0]   e;
    int                            j;
    seen = '0;
    if (len < 1 || len > btc_pkg::TABLE_SLOTS || len > MAX_BLOCK) return 1'b0;
    for (j = 0; j < len; j++) begin
      e = tbl[btc_pkg::ENTRY_W*j +: btc_pkg::ENTRY_W];
      if (e >= len || seen[e]) return 1'b0;
      seen[e] = 1'b1;
    end
    return 1'b1;
  endfunction

  // Gathers one byte; when the block completes, queues the rearranged bytes.
  task automatic absorb_byte(logic [7:0] b, logic eos);
    logic [7:0]         row [btc_pkg::TABLE_SLOTS];
    int                 n;
    int                 j;
    btc_pkg::out_item_t item;
    if (!perm_ok) begin
      if (eos) fill = 0;
      return;
    end
    if (fill < blk_len && fill < MAX_BLOCK) held[fill] = b;
    fill++;
    if (fill < blk_len && !eos) return;
    if (!decrypting) begin
      for (j = fill; j < blk_len; j++) held[j] = btc_pkg::PAD_BYTE;
      for (j = 0; j < blk_len; j++)
        row[j] = held[perm_word[btc_pkg::ENTRY_W*j +: btc_pkg::ENTRY_W]];
      n = blk_len;
    end else begin
      // A short final block cannot be inverted and is dropped whole.
      if (fill < blk_len) begin
        fill = 0;
        return;
      end
      for (j = 0; j < blk_len; j++)
        row[perm_word[btc_pkg::ENTRY_W*j +: btc_pkg::ENTRY_W]] = held[j];
      n = blk_len;
      if (eos)
        while (n > 0 && row[n-1] == btc_pkg::PAD_BYTE) n--;
    end
    fill = 0;
    for (j = 0; j < n; j++) begin
      item.data        = row[j];
      item.block_last  = (j == n - 1);
      item.stream_last = (j == n - 1) && eos;
      cipher_bytes.push_back(item);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      blk_len    = btc_pkg::RESET_BLOCK_LEN;
      perm_word  = btc_pkg::RESET_PERM_TABLE;
      decrypting = 1'b0;
      fill       = 0;
      perm_ok    = 1'b1;
      cipher_bytes.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (cipher_bytes.size() == 0) begin
          $error("out_byte: no transfer expected, got %h", out_byte);
          fail_count++;
        end else begin
          want = cipher_bytes.pop_front();
          if (out_byte !== want.data) begin
            $error("out_byte: expected %h, got %h", want.data, out_byte);
            fail_count++;
          end
          if (block_last !== want.block_last) begin
            $error("block_last: expected %b, got %b", want.block_last, block_last);
            fail_count++;
          end
          if (stream_last !== want.stream_last) begin
            $error("stream_last: expected %b, got %b", want.stream_last, stream_last);
            fail_count++;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          btc_pkg::REG_BLOCK_LEN: begin
            blk_len = cfg_data[btc_pkg::LEN_W-1:0];
            fill    = 0;
            perm_ok = is_permutation(blk_len, perm_word);
          end
          btc_pkg::REG_PERM_TABLE: begin
            perm_word = cfg_data;
            fill      = 0;
            perm_ok   = is_permutation(blk_len, perm_word);
          end
          btc_pkg::REG_DECRYPT_MODE: decrypting = cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) absorb_byte(data_byte, end_of_stream);
    end
    pending_results = cipher_bytes.size();
  end

endmodule

[dv/tb_block_transposition_cipher_top.sv]
module tb_block_transposition_cipher_top;

  localparam int          CLK_PERIOD   = 20;
  localparam int          DRAIN_CYCLES = 50;
  localparam int          TARGET_ITEMS = 120;
  localparam int unsigned MAX_BLOCK    = 16;
  localparam logic [btc_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           cfg_we = 1'b0;
  logic [btc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [btc_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic [7:0]                     data_byte = '0;
  logic                           end_of_stream = 1'b0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic [7:0]                     out_byte;
  logic                           block_last;
  logic                           stream_last;

  int fail_count;
  int pending_results;
  int idle_pct  = 0;
  int stall_pct = 0;
  int items_sent = 0;
  bit table_good = 1'b1;

  int idle_by_phase  [4] = '{0, 67, 0, 17};
  int stall_by_phase [4] = '{0, 0, 67, 17};

  block_transposition_cipher_top #(.MAX_BLOCK(MAX_BLOCK)) dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .data_byte(data_byte), .end_of_stream(end_of_stream),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_byte(out_byte), .block_last(block_last), .stream_last(stream_last)
  );

  btc_stream_checker #(.MAX_BLOCK(MAX_BLOCK)) u_stream_checker (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .data_byte(data_byte), .end_of_stream(end_of_stream),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_byte(out_byte), .block_last(block_last), .stream_last(stream_last),
    .fail_count(fail_count), .pending_results(pending_results)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  always @(negedge clk) begin
    out_stall = ($urandom_range(99) < stall_pct);
  end

  // Random table: entries below len form a shuffle, the rest are left random.
  function automatic logic [63:0] shuffled_table(int len);
    logic [63:0] tbl;
    logic [3:0]  ent [16];
    logic [3:0]  swap;
    int          j;
    int          k;
    tbl = {$urandom, $urandom};
    for (j = 0; j < 16; j++) ent[j] = tbl[4*j +: 4];
    for (j = 0; j < len; j++) ent[j] = 4'(j);
    for (j = len - 1; j > 0; j--) begin
      k = $urandom_range(j);
      swap = ent[j];
      ent[j] = ent[k];
      ent[k] = swap;
    end
    for (j = 0; j < 16; j++) tbl[4*j +: 4] = ent[j];
    return tbl;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic eos);
    while ($urandom_range(99) < idle_pct) @(negedge clk);
    in_valid = 1'b1;
    data_byte = b;
    end_of_stream = eos;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    in_valid = 1'b0;
    if (table_good) items_sent++;
  endtask

  task automatic send_stream(input int len, input logic eos, input int space_pct);
    int i;
    for (i = 0; i < len; i++)
      send_byte(($urandom_range(99) < space_pct) ? btc_pkg::PAD_BYTE : 8'($urandom),
                eos && (i == len - 1));
  endtask

  // Holds the sender back until every predicted byte has been seen, then lets
  // any block that yields nothing finish inside the block.
  task automatic settle();
    wait (pending_results == 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [btc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [btc_pkg::CFG_DATA_W-1:0] value);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic configure(input int len, input logic [63:0] tbl, input bit mode,
                           input bit good);
    logic [63:0] word;
    settle();
    word = {$urandom, $urandom};
    word[4:0] = 5'(len);
    write_reg(btc_pkg::REG_BLOCK_LEN, word);
    write_reg(btc_pkg::REG_PERM_TABLE, tbl);
    word = {$urandom, $urandom};
    word[0] = mode;
    write_reg(btc_pkg::REG_DECRYPT_MODE, word);
    table_good = good;
  endtask

  task automatic random_setup(input bit force_widest);
    int          len;
    int          r;
    int          streams;
    int          s;
    int          i;
    int          nblk;
    int          extra;
    int          spaces;
    bit          mode;
    bit          good;
    logic [63:0] tbl;
    r = $urandom_range(99);
    if (force_widest || r < 10) len = 16;
    else if (r < 15) len = 1;
    else len = $urandom_range(2, 8);
    tbl = shuffled_table(len);
    mode = 1'($urandom_range(1));
    good = 1'b1;
    if ($urandom_range(99) < 10 && !force_widest) begin
      good = 1'b0;
      if (len == 1 || $urandom_range(1)) begin
        len = $urandom_range(1) ? 0 : $urandom_range(17, 31);
      end else begin
        tbl[7:4] = tbl[3:0];
      end
    end
    configure(len, tbl, mode, good);
    streams = $urandom_range(1, 3);
    for (s = 0; s < streams; s++) begin
      if ($urandom_range(99) < 15) begin
        // Loose bytes with end-of-stream marks at arbitrary points.
        nblk = $urandom_range(1, 20);
        for (i = 0; i < nblk; i++) send_byte(8'($urandom), $urandom_range(7) == 0);
      end else begin
        nblk = $urandom_range(0, 3);
        extra = (len > 1 && len <= 16 && $urandom_range(1)) ? $urandom_range(1, len - 1) : 0;
        r = nblk * len + extra;
        if (r == 0) r = (len > 0 && len <= 16) ? len : 3;
        spaces = mode ? 40 : 10;
        if ($urandom_range(99) < 5) spaces = 100;
        send_stream(r, 1'b1, spaces);
      end
    end
  endtask

  initial begin
    int p;
    int phase_goal;
    repeat (7) @(negedge clk);
    rst = 1'b0;

    // Reset settings: one-byte blocks, identity table.
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);

    // Reversed four-byte table: one full block, then a padded partial one.
    configure(4, 64'hFFFF_FFFF_FFFF_0123, 1'b0, 1'b1);
    send_stream(6, 1'b1, 20);

    // Decrypt: a final block of spaces strips to nothing; a short final block
    // is dropped.
    settle();
    write_reg(btc_pkg::REG_DECRYPT_MODE, 64'd1);
    send_stream(4, 1'b1, 100);
    send_stream(6, 1'b1, 50);

    // Table entry out of range, then a repeated entry.
    configure(4, '1, 1'b0, 1'b0);
    send_stream(2, 1'b1, 0);
    settle();
    write_reg(btc_pkg::REG_PERM_TABLE, '0);
    send_stream(1, 1'b1, 0);

    // Lengths out of range and a write to an unused index.
    settle();
    write_reg(btc_pkg::REG_BLOCK_LEN, 64'd0);
    write_reg(btc_pkg::REG_BLOCK_LEN, 64'd31);
    write_reg(REG_SPARE, {$urandom, $urandom});
    configure(17, btc_pkg::RESET_PERM_TABLE, 1'b0, 1'b0);
    send_stream(1, 1'b1, 0);

    // A table write discards the partial block held so far.
    configure(3, btc_pkg::RESET_PERM_TABLE, 1'b0, 1'b1);
    send_stream(2, 1'b0, 0);
    settle();
    write_reg(btc_pkg::REG_PERM_TABLE, 64'hFEDC_BA98_7654_3021);
    send_stream(3, 1'b1, 0);

    items_sent = 0;
    for (p = 0; p < 4; p++) begin
      idle_pct = idle_by_phase[p];
      stall_pct = stall_by_phase[p];
      phase_goal = TARGET_ITEMS * (p + 1) / 4;
      random_setup(p == 0);
      while (items_sent < phase_goal) random_setup(1'b0);
    end

    wait (pending_results == 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #(CLK_PERIOD * 500000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
